/* rtl/sorted_ready_queue_top_assert.svh */
// Assertion macros for the sorted ready queue checker.
`ifndef SORTED_READY_QUEUE_TOP_ASSERT_SVH
`define SORTED_READY_QUEUE_TOP_ASSERT_SVH

// Clocked assertion, masked while reset is held.
`define SRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SRQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/srq_pkg.sv */
// Shared types, constants and key selection for the sorted ready queue.
package srq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] MODE_ID    = 2'd0;
    localparam logic [1:0] MODE_PRIO  = 2'd1;
    localparam logic [1:0] MODE_BURST = 2'd2;

    localparam logic REG_SORT_MODE = 1'b0;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  burst;
        logic [7:0]  prio;
        logic [7:0]  id;
    } t_entry;

    typedef struct packed {
        logic       ins;
        logic       rem;
        logic [1:0] mode;
    } t_cell_ctrl;

    function automatic logic [7:0] key_of(input t_entry e, input logic [1:0] mode);
        logic [7:0] k;
        case (mode)
            MODE_PRIO:  k = e.prio;
            MODE_BURST: k = e.burst;
            default:    k = e.id;
        endcase
        return k;
    endfunction

endpackage

/* rtl/srq_cell.sv */
// One queue slot: holds an entry and shifts with its neighbors on insert and remove.
module srq_cell
    import srq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new_entry,
    input  t_entry     i_left_entry,
    input  t_entry     i_right_entry,
    input  logic       i_occ,
    input  logic       i_at_tail,
    input  logic       i_below,
    output logic       o_below,
    output t_entry     o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    logic   mark;

    // First slot whose key exceeds the new key, or the tail, is where it lands.
    assign mark = i_occ ? (key_of(r_entry, i_ctrl.mode) > key_of(i_new_entry, i_ctrl.mode))
                        : i_at_tail;
    assign o_below = i_below | mark;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (i_below) begin
                n_entry = i_left_entry;
            end else if (mark) begin
                n_entry = i_new_entry;
            end
        end else if (i_ctrl.rem) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* rtl/sorted_ready_queue_top.sv */
// Top level of the sorted ready queue: cell chain, count, result register, APB register.
//
// channel   dir  handshake                   payload
// s_axis    in   i_s_axis_tvalid/o_tready    tdata: prio,burst,id,handle; tuser: op
// m_axis    out  o_m_axis_tvalid/i_tready    tdata: id,prio,burst,handle,occ; tuser: status
// apb       in   psel & penable & pwrite     sort_mode at byte address 0
//
// Each item is handled whole: all cells compare against the new key at
// once and shift together; the result lands in the output register next edge.
// One item per cycle is sustained while the output is taken.
// Reset empties the queue at once; slot contents need no clearing.
// A held output stalls the input only when a new result would overwrite it.
module sorted_ready_queue_top
    import srq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] priority_req, [15:8] burst_time, [23:16] task_id, [39:24] task_handle
    input  logic [39:0] i_s_axis_tdata,
    // [0] op
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_task_id, [15:8] out_priority, [23:16] out_burst_time,
    // [39:24] out_task_handle, [44:40] occupancy, [47:45] zero
    output logic [47:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    t_entry           r_out_entry;
    logic [OCC_W-1:0] r_out_occ;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    t_cell_ctrl ctrl;
    t_entry     new_entry;
    logic       cfg_wr;

    t_entry     cell_q   [QUEUE_DEPTH];
    logic       below_in [QUEUE_DEPTH+1];

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite & (i_paddr[2] == REG_SORT_MODE);
    assign o_prdata = (i_paddr[2] == REG_SORT_MODE) ? {30'd0, r_mode} : 32'd0;

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    assign new_entry.prio   = i_s_axis_tdata[7:0];
    assign new_entry.burst  = i_s_axis_tdata[15:8];
    assign new_entry.id     = i_s_axis_tdata[23:16];
    assign new_entry.handle = i_s_axis_tdata[39:24];

    assign ctrl.ins  = accept & (i_s_axis_tuser == OP_INSERT) & ~is_full;
    assign ctrl.rem  = accept & (i_s_axis_tuser == OP_REMOVE) & ~is_empty;
    assign ctrl.mode = r_mode;

    assign below_in[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        srq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_new_entry   (new_entry),
            .i_left_entry  ((i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i-1]),
            .i_right_entry (cell_q[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .i_occ         (CNT_W'(i) < r_count),
            .i_at_tail     (CNT_W'(i) == r_count),
            .i_below       (below_in[i]),
            .o_below       (below_in[i+1]),
            .o_entry       (cell_q[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ID;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_mode <= i_pwdata[1:0];
            end
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_occ   <= n_count[OCC_W-1:0];
            r_out_entry <= ctrl.rem ? cell_q[0] : '0;
            if (i_s_axis_tuser == OP_REMOVE) begin
                r_out_status <= is_empty ? ST_EMPTY : ST_DONE;
            end else begin
                r_out_status <= is_full ? ST_FULL : ST_DONE;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'd0, r_out_occ, r_out_entry.handle, r_out_entry.burst,
                              r_out_entry.prio, r_out_entry.id};

endmodule

/* rtl/srq_checker.sv */
// Port-level checks for the sorted ready queue, bound to the top level.
`include "sorted_ready_queue_top_assert.svh"

module srq_checker
    import srq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [39:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [2:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] o_prdata,
    input logic        o_pready
);

    `SRQ_ASSERT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed while stalled")
    `SRQ_ASSERT(a_empty_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY |-> o_m_axis_tdata[44:0] == 45'd0, "empty remove returned data")
    `SRQ_ASSERT(a_full_occ, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser == ST_FULL |-> o_m_axis_tdata[44:40] == OCC_W'(QUEUE_DEPTH) && o_m_axis_tdata[39:0] == 40'd0, "full flag with wrong occupancy")
    `SRQ_ASSERT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid, "accepted item gave no result")
    `SRQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind sorted_ready_queue_top srq_checker u_srq_checker (.*);
